FILE: rtl/kmsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmsd_pkg: shared definitions for the key matrix shift debouncer
// Field widths, parameter defaults, configuration register indexes and the
// sample window mask function.
// ----------------------------------------------------------------------------
package kmsd_pkg;

    localparam int ROWS_DEFAULT = 8;
    localparam int COLS_DEFAULT = 16;

    localparam int HIST_W    = 8;   // samples of history kept per key
    localparam int ROW_IDX_W = 3;   // width of the row index field
    localparam int ROW_W     = 16;  // width of the raw and debounced row fields
    localparam int CFG_W     = 4;   // width of a configuration register
    localparam int CFG_IDX_W = 1;   // width of the register index

    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_COUNT   = 1'b1;

    // Mask of the newest n samples; a count of zero acts as one and a count
    // above eight acts as eight.
    function automatic logic [HIST_W-1:0] window_mask(input logic [CFG_W-1:0] n);
        logic [CFG_W-1:0] n_clamped;
        n_clamped = n;
        if (n_clamped == '0) begin
            n_clamped = CFG_W'(1);
        end
        if (n_clamped > CFG_W'(HIST_W)) begin
            n_clamped = CFG_W'(HIST_W);
        end
        return HIST_W'({HIST_W{1'b1}} >> (CFG_W'(HIST_W) - n_clamped));
    endfunction

endpackage : kmsd_pkg
`default_nettype wire

FILE: rtl/kmsd_row_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmsd_row_mem: per-row state store
// One entry per matrix row with a registered read port, a write port that is
// forwarded to a read of the same row in the same cycle, and a valid bit per
// row so that a row never written since reset reads as zero.
// ----------------------------------------------------------------------------
module kmsd_row_mem
    import kmsd_pkg::*;
#(
    parameter int ROWS  = ROWS_DEFAULT,
    parameter int WIDTH = COLS_DEFAULT * (HIST_W + 1),
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [ROWS];
    logic [ROWS-1:0]  row_valid_reg;
    logic [WIDTH-1:0] mem_rd_reg;
    logic             fwd_reg;
    logic             valid_rd_reg;
    logic [WIDTH-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_valid_reg <= '0;
        end else if (wr_en) begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // The read data is held while no new read is requested, so a stalled
    // consumer keeps seeing the row it asked for.
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    // The valid check and the write forwarding sit beside the raw array read.
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            fwd_reg      <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
            valid_rd_reg <= row_valid_reg[rd_addr];
        end
    end

    always_comb
    begin
        if (fwd_reg) begin
            rd_data = fwd_data_reg;
        end else if (valid_rd_reg) begin
            rd_data = mem_rd_reg;
        end else begin
            rd_data = '0;
        end
    end

endmodule : kmsd_row_mem
`default_nettype wire

FILE: rtl/kmsd_row_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmsd_row_update: debounce update of one row
// Shifts each key's new raw sample into its history and sets, clears or
// holds the key's debounced bit from the newest samples.
// ----------------------------------------------------------------------------
module kmsd_row_update
    import kmsd_pkg::*;
#(
    parameter int COLS = COLS_DEFAULT
)
(
    input  wire logic [COLS*HIST_W-1:0] hist_in,
    input  wire logic [COLS-1:0]        deb_in,
    input  wire logic [ROW_W-1:0]       raw_row,
    input  wire logic [HIST_W-1:0]      down_mask,
    input  wire logic [HIST_W-1:0]      up_mask,
    output logic      [COLS*HIST_W-1:0] hist_out,
    output logic      [COLS-1:0]        deb_out
);

    localparam int RAW_WIDE_W = (COLS > ROW_W) ? COLS : ROW_W;

    logic [RAW_WIDE_W-1:0] raw_wide;

    // Columns at sixteen and above have no raw input and always sample zero.
    assign raw_wide = RAW_WIDE_W'(raw_row);

    always_comb
    begin
        logic [HIST_W-1:0] h;
        hist_out = '0;
        deb_out  = '0;
        for (int c = 0; c < COLS; c++) begin
            h = {hist_in[c*HIST_W +: HIST_W-1], raw_wide[c]};
            hist_out[c*HIST_W +: HIST_W] = h;
            if ((h & down_mask) == down_mask) begin
                deb_out[c] = 1'b1;
            end else if ((~h & up_mask) == up_mask) begin
                deb_out[c] = 1'b0;
            end else begin
                deb_out[c] = deb_in[c];
            end
        end
    end

endmodule : kmsd_row_update
`default_nettype wire

FILE: rtl/key_matrix_shift_debouncer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_matrix_shift_debouncer_core: shift-register history key debouncer
// Takes one scanned row of raw key bits per transaction, keeps an 8-sample
// history per key and returns the updated debounced row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carry row_index and raw_row. A
//   transaction completes on a rising edge with in_valid high and in_stall
//   low. Output channel: out_valid / out_stall carry out_row_index and
//   debounced_row, one result transaction per input transaction, in order.
//   The accepting edge loads the sample stage and reads the row state from
//   the row store; the edge at which the sample stage advances runs the
//   per-key update, writes the row back and loads the output register.
//   Throughput is one row per cycle while the receiver does not stall, also
//   when the same row arrives on consecutive cycles: a write-back is
//   forwarded to a read of the same row.
//   When the receiver stalls, the output register holds its result and the
//   sample stage holds its row; in_stall rises only when both are full.
//   Reset clears both pipeline stages and the per-row valid bits, so every
//   history and debounced row reads as zero with no clearing pass. The window
//   registers reset to five samples each.
//   The user must write configuration (cfg_wr_en, cfg_index, cfg_data) only
//   while no transaction is in flight; the block does not enforce it. A row
//   index at or above ROWS leaves the state untouched, returns an all-zero debounced row.
// ----------------------------------------------------------------------------
module key_matrix_shift_debouncer_core
    import kmsd_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // Input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [ROW_IDX_W-1:0] row_index,
    input  wire logic [ROW_W-1:0]     raw_row,
    // Output channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [ROW_IDX_W-1:0] out_row_index,
    output logic      [ROW_W-1:0]     debounced_row
);

    localparam int AW         = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_WIDE_W = (AW > ROW_IDX_W) ? AW : ROW_IDX_W;
    localparam int HIST_ROW_W = COLS * HIST_W;
    localparam int ENTRY_W    = HIST_ROW_W + COLS;
    localparam int DEB_WIDE_W = (COLS > ROW_W) ? COLS : ROW_W;

    // ------------------------------------------------------------------
    // Window mask registers. The masks are stored already decoded so the
    // update path only compares.
    // ------------------------------------------------------------------
    logic [HIST_W-1:0] down_mask_reg;
    logic [HIST_W-1:0] up_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            down_mask_reg <= window_mask(CFG_W'(5));
            up_mask_reg   <= window_mask(CFG_W'(5));
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DOWN_COUNT: down_mask_reg <= window_mask(cfg_data);
                CFG_UP_COUNT:   up_mask_reg   <= window_mask(cfg_data);
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The sample stage moves on whenever the output register is
    // empty or being drained; the input stalls only when the sample stage
    // is full and cannot move.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic s1_advance;
    logic in_accept;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_accept  = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_advance) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Sample stage: the accepted row index and raw bits, aligned with the
    // registered read of that row's state.
    // ------------------------------------------------------------------
    logic [IDX_WIDE_W-1:0] row_index_wide;
    logic [AW-1:0]         in_addr;
    logic                  in_range;

    assign row_index_wide = IDX_WIDE_W'(row_index);
    assign in_addr        = row_index_wide[AW-1:0];
    assign in_range       = (int'(row_index) < ROWS);

    logic [ROW_IDX_W-1:0] s1_row_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic                 s1_in_range_reg;
    logic [ROW_W-1:0]     s1_raw_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            s1_row_reg      <= row_index;
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_range;
            s1_raw_reg      <= raw_row;
        end
    end

    // ------------------------------------------------------------------
    // Row store: each entry holds the histories of all keys of a row and
    // the row's debounced bits.
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] entry_rd;
    logic [ENTRY_W-1:0] entry_wr;
    logic               entry_wr_en;

    assign entry_wr_en = s1_advance && s1_in_range_reg;

    kmsd_row_mem #(
        .ROWS  (ROWS),
        .WIDTH (ENTRY_W)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (in_addr),
        .rd_data (entry_rd),
        .wr_en   (entry_wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (entry_wr)
    );

    // ------------------------------------------------------------------
    // Per-key update of the row in the sample stage.
    // ------------------------------------------------------------------
    logic [HIST_ROW_W-1:0] hist_new;
    logic [COLS-1:0]       deb_new;

    kmsd_row_update #(
        .COLS (COLS)
    ) u_row_update (
        .hist_in   (entry_rd[HIST_ROW_W-1:0]),
        .deb_in    (entry_rd[ENTRY_W-1:HIST_ROW_W]),
        .raw_row   (s1_raw_reg),
        .down_mask (down_mask_reg),
        .up_mask   (up_mask_reg),
        .hist_out  (hist_new),
        .deb_out   (deb_new)
    );

    assign entry_wr = {deb_new, hist_new};

    // Columns beyond COLS read as zero; columns at sixteen and above are
    // kept in the store but do not fit the result field.
    logic [DEB_WIDE_W-1:0] deb_wide;

    assign deb_wide = DEB_WIDE_W'(deb_new);

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic [ROW_IDX_W-1:0] out_row_index_reg;
    logic [ROW_W-1:0]     debounced_row_reg;

    always_ff @(posedge clk)
    begin
        if (s1_advance) begin
            out_row_index_reg <= s1_row_reg;
            debounced_row_reg <= s1_in_range_reg ? deb_wide[ROW_W-1:0] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row_index = out_row_index_reg;
    assign debounced_row = debounced_row_reg;

endmodule : key_matrix_shift_debouncer_core
`default_nettype wire

FILE: tb/sv/key_matrix_shift_debouncer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_shift_debouncer_core_tb: self-checking bench for the debouncer
// Drives row scans through the valid/stall input channel and predicts every
// debounced row from its own per-key history. The predictions are compared
// in order with the output channel across several window settings, with
// random idle cycles on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module key_matrix_shift_debouncer_core_tb
    import kmsd_pkg::*;
;

    localparam int NUM_ROWS     = ROWS_DEFAULT;
    localparam int NUM_COLS     = COLS_DEFAULT;
    // Margin allowed after the last result comes back, before a register write
    // or the final verdict.
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [ROW_IDX_W-1:0] row;
        logic [ROW_W-1:0]     bits;
    } debounced_result_t;

    // Tracks the per-key sample history and the debounced rows exactly as the
    // block should, and keeps the debounced rows still owed by the block.
    class row_debounce_tracker;
        logic [HIST_W-1:0] history [NUM_ROWS][NUM_COLS];
        logic [ROW_W-1:0]  deb_state [NUM_ROWS];
        logic [CFG_W-1:0]  down_len;
        logic [CFG_W-1:0]  up_len;
        debounced_result_t expected_rows [$];
        int                failures;
        int                rows_noted;
        int                rows_checked;

        function new();
            foreach (history[r, c])
            begin
                history[r][c] = '0;
            end
            foreach (deb_state[r])
            begin
                deb_state[r] = '0;
            end
            down_len     = CFG_W'(5);
            up_len       = CFG_W'(5);
            failures     = 0;
            rows_noted   = 0;
            rows_checked = 0;
        endfunction

        // A window length of zero behaves as one sample, above eight as eight.
        function logic [HIST_W-1:0] window_of(logic [CFG_W-1:0] len);
            int samples;
            samples = (len == 0) ? 1 : ((len > HIST_W) ? HIST_W : int'(len));
            return HIST_W'((9'h1 << samples) - 9'h1);
        endfunction

        function void set_window(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx == CFG_DOWN_COUNT)
            begin
                down_len = value;
            end
            else if (idx == CFG_UP_COUNT)
            begin
                up_len = value;
            end
        endfunction

        function void note_scan(logic [ROW_IDX_W-1:0] row, logic [ROW_W-1:0] raw);
            logic [HIST_W-1:0] press_win;
            logic [HIST_W-1:0] release_win;
            logic [HIST_W-1:0] hist;
            debounced_result_t res;
            int c;
            press_win   = window_of(down_len);
            release_win = window_of(up_len);
            res.row  = row;
            res.bits = '0;
            if (int'(row) < NUM_ROWS)
            begin
                res.bits = deb_state[row];
                for (c = 0; c < NUM_COLS; c++)
                begin
                    hist = {history[row][c][HIST_W-2:0], raw[c]};
                    history[row][c] = hist;
                    if ((hist & press_win) == press_win)
                    begin
                        res.bits[c] = 1'b1;
                    end
                    else if ((~hist & release_win) == release_win)
                    begin
                        res.bits[c] = 1'b0;
                    end
                end
                deb_state[row] = res.bits;
            end
            expected_rows.push_back(res);
            rows_noted++;
        endfunction

        function void check_row(logic [ROW_IDX_W-1:0] row, logic [ROW_W-1:0] bits);
            debounced_result_t want;
            if (expected_rows.size() == 0)
            begin
                $display("%0t: unexpected result transaction, row %0d bits %h",
                         $time, row, bits);
                failures++;
                return;
            end
            want = expected_rows.pop_front();
            rows_checked++;
            if (row !== want.row)
            begin
                $display("%0t: out_row_index mismatch, expected %0d, actual %0d",
                         $time, want.row, row);
                failures++;
            end
            if (bits !== want.bits)
            begin
                $display("%0t: debounced_row mismatch (row %0d), expected %h, actual %h",
                         $time, want.row, want.bits, bits);
                failures++;
            end
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction
    endclass

    // Block ports. Every input starts at a known value.
    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_DOWN_COUNT;
    logic [CFG_W-1:0]     cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [ROW_IDX_W-1:0] row_index     = '0;
    logic [ROW_W-1:0]     raw_row       = '0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [ROW_IDX_W-1:0] out_row_index;
    logic [ROW_W-1:0]     debounced_row;

    row_debounce_tracker tracker = new();

    // Idle control shared between the stimulus and the receiver process.
    bit send_idle     = 1'b0;
    bit recv_idle     = 1'b0;
    bit long_hold_req = 1'b0;
    int window_settings = 0;
    int cycle_count     = 0;

    // Keys that are "really" held on each row; scans are built around them.
    logic [ROW_W-1:0]     held_keys [NUM_ROWS];
    logic [ROW_IDX_W-1:0] focus_row = '0;

    key_matrix_shift_debouncer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .row_index     (row_index),
        .raw_row       (raw_row),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_row_index (out_row_index),
        .debounced_row (debounced_row)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, tracker.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        else if (roll < 85)
        begin
            return $urandom_range(1, 2);
        end
        else if (roll < 97)
        begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(15, 30);
    endfunction

    // Receiver. Outputs are sampled at the rising edge, before this edge's
    // updates land, and the next stall value is chosen at the same edge. A
    // long hold-off request keeps out_stall high long enough that the
    // pipeline fills and the block pushes back on its input.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                tracker.check_row(out_row_index, debounced_row);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (recv_idle && $urandom_range(0, 3) == 0)
            begin
                stall_left = idle_len();
                out_stall <= (stall_left > 0);
                if (stall_left > 0)
                begin
                    stall_left--;
                end
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offers one row scan and returns at the edge where the transaction
    // completes. Called at a rising edge; in_valid stays high when the next
    // scan follows without a gap, so it is never lowered and raised in one
    // time step.
    task automatic send_scan(input logic [ROW_IDX_W-1:0] row, input logic [ROW_W-1:0] raw);
        int gap;
        gap = send_idle ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_index <= row;
        raw_row   <= raw;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        tracker.note_scan(row, raw);
    endtask

    // Stops offering scans and waits until every debounced row has come back,
    // plus a few cycles of margin so the block is idle for a register write.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_window(idx, value);
    endtask

    task automatic set_windows(input logic [CFG_W-1:0] down_len, input logic [CFG_W-1:0] up_len);
        write_reg(CFG_DOWN_COUNT, down_len);
        write_reg(CFG_UP_COUNT, up_len);
        window_settings++;
    endtask

    // Random scans. Most follow the keys held on a row, sometimes with a
    // short bounce or a key going down or up; the rest are pure noise. Scans
    // tend to stay on one row for a while so histories fill up.
    task automatic run_scans(input int count);
        logic [ROW_IDX_W-1:0] row;
        logic [ROW_W-1:0]     raw;
        int n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                focus_row = ROW_IDX_W'($urandom_range(0, NUM_ROWS - 1));
            end
            row = focus_row;
            if ($urandom_range(0, 9) < 2)
            begin
                raw = ROW_W'($urandom);
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    held_keys[row] ^= ROW_W'(1) << $urandom_range(0, ROW_W - 1);
                end
                raw = held_keys[row];
                if ($urandom_range(0, 3) == 0)
                begin
                    raw ^= ROW_W'($urandom & $urandom & $urandom);
                end
            end
            send_scan(row, raw);
        end
    endtask

    // Main sequence.
    initial
    begin
        int k;
        int p;
        foreach (held_keys[r])
        begin
            held_keys[r] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed scans under the reset windows of five samples each. Row 0
        // is pressed on every key until it goes down, then released until it
        // goes up; row 7 bounces and must hold; row 3 sees one lone press.
        for (k = 0; k < 5; k++)
        begin
            send_scan(ROW_IDX_W'(0), 16'hFFFF);
        end
        for (k = 0; k < 5; k++)
        begin
            send_scan(ROW_IDX_W'(0), 16'h0000);
        end
        send_scan(ROW_IDX_W'(7), 16'hAAAA);
        send_scan(ROW_IDX_W'(7), 16'h5555);
        send_scan(ROW_IDX_W'(7), 16'hAAAA);
        send_scan(ROW_IDX_W'(7), 16'h5555);
        send_scan(ROW_IDX_W'(3), 16'hFFFF);
        drain();

        // A press window of zero acts as one sample and a release window of
        // fifteen acts as eight: row 1 goes down at once and then holds
        // through a short release.
        set_windows(CFG_W'(0), CFG_W'(15));
        send_scan(ROW_IDX_W'(1), 16'hF0F0);
        send_scan(ROW_IDX_W'(1), 16'h0000);
        send_scan(ROW_IDX_W'(1), 16'h0000);
        send_scan(ROW_IDX_W'(6), 16'h8001);
        send_scan(ROW_IDX_W'(4), 16'h7FFE);
        drain();

        // Random phase with the same odd windows, idling on both sides.
        send_idle = 1'b1;
        recv_idle = 1'b1;
        run_scans(80);
        drain();

        // Both windows at the full eight samples. The receiver holds off for a
        // long stretch while scans keep coming back to back.
        set_windows(CFG_W'(8), CFG_W'(8));
        send_idle     = 1'b0;
        recv_idle     = 1'b0;
        long_hold_req = 1'b1;
        run_scans(100);
        drain();

        // Shortest windows: every scan decides each key on its own.
        set_windows(CFG_W'(1), CFG_W'(1));
        send_idle = 1'b1;
        recv_idle = 1'b1;
        run_scans(80);
        drain();

        // Random window settings over the whole register range, with the
        // idle pattern changing from phase to phase.
        for (p = 0; p < 4; p++)
        begin
            set_windows(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)));
            send_idle = p[0];
            recv_idle = p[1];
            run_scans(85);
            drain();
        end

        $display("Summary: %0d row scans sent, %0d debounced rows checked, %0d window settings.",
                 tracker.rows_noted, tracker.rows_checked, window_settings);
        $display("Covered odd windows, idle gaps on both sides and a %0d-cycle hold-off.",
                 HOLD_CYCLES);
        if (tracker.failures == 0 && tracker.pending() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule : key_matrix_shift_debouncer_core_tb
